>>> hw/rtl/scps_pkg.sv
`default_nettype none

package scps_pkg;

  localparam int unsigned LineBufferBytesDef = 64;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PeriodW = 30;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned MagW    = 31;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CntW    = $clog2(PeriodW + 1);
  localparam int unsigned OutDataW = 64;

  // The period is split as period = 100 * hundreds + rest.
  localparam int unsigned RecipW     = 31;
  localparam int unsigned RecipShift = 37;
  localparam int unsigned QuotW      = PeriodW + RecipW - RecipShift;
  localparam int unsigned ScaleW     = 2 * DutyW + 13;
  localparam int unsigned FineShift  = 19;

  localparam logic [PeriodW-1:0] NsPerS     = PeriodW'(1000000000);
  localparam logic [MagW-1:0]    MagMax     = MagW'(2147483647);
  localparam logic [MagW-1:0]    FreqReset  = MagW'(5000);
  localparam logic [DutyW-1:0]   DutyReset  = DutyW'(50);
  localparam logic [DutyW-1:0]   DutyMax    = DutyW'(100);
  localparam logic [MagW-1:0]    Hundred    = MagW'(100);
  localparam logic [RecipW-1:0]  Recip100   = RecipW'(1374389535);
  localparam logic [ScaleW-1:0]  FineMul    = ScaleW'(5243);

  localparam logic [ByteW-1:0] ChD     = 8'h44;
  localparam logic [ByteW-1:0] ChF     = 8'h46;
  localparam logic [ByteW-1:0] ChE     = 8'h45;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChVt    = 8'h0B;
  localparam logic [ByteW-1:0] ChFf    = 8'h0C;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  localparam logic [PhaseW-1:0] PhSkip   = 2'd0;
  localparam logic [PhaseW-1:0] PhSign   = 2'd1;
  localparam logic [PhaseW-1:0] PhDigits = 2'd2;
  localparam logic [PhaseW-1:0] PhDone   = 2'd3;

  typedef struct packed {
    logic take;
    logic div_load;
    logic div_step;
    logic recip;
    logic split;
    logic scale;
    logic res_zero;
    logic out_load;
  } scps_cmd_t;

  typedef struct packed {
    logic line_done;
    logic motor_on;
    logic div_done;
    logic out_free;
  } scps_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/scps_ctrl.sv
`default_nettype none

module scps_ctrl
  import scps_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  scps_sts_t      sts_i,
  output scps_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPrep  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StRecip = 3'd3;
  localparam logic [2:0] StSplit = 3'd4;
  localparam logic [2:0] StScale = 3'd5;
  localparam logic [2:0] StLoad  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.line_done) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        if (sts_i.motor_on) begin
          cmd_o.div_load = 1'b1;
          state_d = StDiv;
        end else begin
          cmd_o.res_zero = 1'b1;
          state_d = StLoad;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StRecip;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StRecip: begin
        cmd_o.recip = 1'b1;
        state_d = StSplit;
      end
      StSplit: begin
        cmd_o.split = 1'b1;
        state_d = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d = StLoad;
      end
      StLoad: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scps_dp.sv
`default_nettype none

module scps_dp
  import scps_pkg::*;
#(
  parameter int unsigned LINE_BUFFER_BYTES = LineBufferBytesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ByteW-1:0]  rx_byte_i,
  input  scps_cmd_t              cmd_i,
  output scps_sts_t              sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [PeriodW-1:0]     period_o,
  output logic [PeriodW-1:0]     high_o,
  output logic                   motor_on_o
);

  localparam int unsigned LenW = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_BUFFER_BYTES - 1);

  logic [LenW-1:0]   len_q, len_d;
  logic              ended_q, ended_d;
  logic              long_q, long_d;
  logic [ByteW-1:0]  letter_q, letter_d;
  logic [ByteW-1:0]  second_q, second_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [MagW-1:0]   mag_q, mag_d;
  logic [MagW-1:0]   freq_q, freq_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic              en_q, en_d;

  logic              is_term;
  logic              is_digit;
  logic              is_space;
  logic [MagW+3:0]   mag_next;
  logic [MagW-1:0]   val;

  assign is_term  = (rx_byte_i == ChLf) || (rx_byte_i == ChCr);
  assign is_digit = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign is_space = (rx_byte_i == ChSpace) || (rx_byte_i == ChTab) ||
                    (rx_byte_i == ChVt) || (rx_byte_i == ChFf);
  assign mag_next = (MagW+4)'({mag_q, 3'b000}) + (MagW+4)'({mag_q, 1'b0}) +
                    (MagW+4)'(rx_byte_i - ChZero);
  assign val      = neg_q ? '0 : mag_q;

  always_comb begin
    len_d    = len_q;
    ended_d  = ended_q;
    long_d   = long_q;
    letter_d = letter_q;
    second_d = second_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    freq_d   = freq_q;
    duty_d   = duty_q;
    en_d     = en_q;
    if (cmd_i.take) begin
      if (is_term) begin
        if (len_q != '0) begin
          if (long_q && (second_q == ChColon)) begin
            if (letter_q == ChD) begin
              duty_d = (val > MagW'(DutyMax)) ? DutyMax : val[DutyW-1:0];
            end else if (letter_q == ChF) begin
              freq_d = val;
            end else if (letter_q == ChE) begin
              en_d = (mag_q != '0);
            end
          end
          len_d    = '0;
          ended_d  = 1'b0;
          long_d   = 1'b0;
          letter_d = '0;
          second_d = '0;
          phase_d  = PhSkip;
          neg_d    = 1'b0;
          mag_d    = '0;
        end
      end else if (len_q != LenLast) begin
        len_d = len_q + LenW'(1);
        if (!ended_q) begin
          if (rx_byte_i == ChNul) begin
            ended_d = 1'b1;
          end else if (len_q == LenW'(0)) begin
            letter_d = rx_byte_i;
          end else if (len_q == LenW'(1)) begin
            second_d = rx_byte_i;
          end else begin
            long_d = 1'b1;
            if ((phase_q == PhSkip) && is_space) begin
              phase_d = phase_q;
            end else if ((phase_q == PhSkip) &&
                         ((rx_byte_i == ChPlus) || (rx_byte_i == ChMinus))) begin
              neg_d   = (rx_byte_i == ChMinus);
              phase_d = PhSign;
            end else if ((phase_q != PhDone) && is_digit) begin
              mag_d   = (mag_next > (MagW+4)'(MagMax)) ? MagMax : mag_next[MagW-1:0];
              phase_d = PhDigits;
            end else begin
              phase_d = PhDone;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ended_q  <= 1'b0;
      long_q   <= 1'b0;
      letter_q <= '0;
      second_q <= '0;
      phase_q  <= PhSkip;
      neg_q    <= 1'b0;
      mag_q    <= '0;
      freq_q   <= FreqReset;
      duty_q   <= DutyReset;
      en_q     <= 1'b0;
    end else begin
      len_q    <= len_d;
      ended_q  <= ended_d;
      long_q   <= long_d;
      letter_q <= letter_d;
      second_q <= second_d;
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      freq_q   <= freq_d;
      duty_q   <= duty_d;
      en_q     <= en_d;
    end
  end

  // Restoring divider for the period. The high time is then built as
  // hundreds * duty + (rest * duty) / 100, both divisions by reciprocals.
  logic [PeriodW-1:0]        quot_q;
  logic [MagW-1:0]           rem_q;
  logic [MagW-1:0]           divisor_q;
  logic [CntW-1:0]           cnt_q;
  logic [MagW:0]             rem_shift;
  logic                      fits;
  logic [PeriodW-1:0]        period_q;
  logic [PeriodW+RecipW-1:0] recip_prod;
  logic [QuotW-1:0]          hund_q;
  logic [DutyW-1:0]          rest_q;
  logic [PeriodW-1:0]        coarse_q;
  logic [ScaleW-1:0]         scale_prod;
  logic [DutyW-1:0]          fine_q;
  logic                      motor_en;

  assign rem_shift  = {rem_q, quot_q[PeriodW-1]};
  assign fits       = rem_shift >= {1'b0, divisor_q};
  assign recip_prod = (PeriodW+RecipW)'(quot_q) * (PeriodW+RecipW)'(Recip100);
  assign scale_prod = ScaleW'(rest_q) * ScaleW'(duty_q) * FineMul;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quot_q    <= NsPerS;
      rem_q     <= '0;
      divisor_q <= freq_q;
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[PeriodW-2:0], fits};
      rem_q  <= fits ? MagW'(rem_shift - {1'b0, divisor_q}) : rem_shift[MagW-1:0];
    end
    if (cmd_i.res_zero) begin
      period_q <= '0;
      coarse_q <= '0;
      fine_q   <= '0;
    end else begin
      if (cmd_i.recip) begin
        period_q <= quot_q;
        hund_q   <= recip_prod[RecipShift +: QuotW];
      end
      if (cmd_i.split) begin
        rest_q   <= DutyW'(period_q - PeriodW'(hund_q) * PeriodW'(Hundred));
        coarse_q <= PeriodW'(hund_q) * PeriodW'(duty_q);
      end
      if (cmd_i.scale) begin
        fine_q <= scale_prod[FineShift +: DutyW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= CntW'(PeriodW);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      period_o   <= period_q;
      high_o     <= coarse_q + PeriodW'(fine_q);
      motor_on_o <= motor_en;
    end
  end

  assign motor_en    = en_q && (duty_q != '0) && (freq_q != '0);
  assign out_valid_o = out_valid_q;
  assign sts_o       = {is_term && (len_q != '0) && long_q, motor_en, cnt_q == '0,
                        !out_valid_q || out_ready_i};

endmodule

`default_nettype wire

>>> hw/rtl/serial_command_pwm_setter.sv
`default_nettype none

// Channel   Direction  Handshake                        Content
// input     slave      s_axis_tvalid_i/s_axis_tready_o  one received byte
// result    master     m_axis_tvalid_o/m_axis_tready_i  period, high time, motor flag
//
// A byte that does not end a line, or ends one without a result, is taken at once.
// A line end that turns the output on holds the input while the result is computed:
// 30 divider steps for the period, then the reciprocal, split and scale steps.
// A line end that switches the output off gives a zero result without these steps.
// Bytes keep flowing while a result waits; the next result stalls the input until it
// is taken. Reset is asynchronous and active low.

module serial_command_pwm_setter
  import scps_pkg::*;
#(
  parameter int unsigned LINE_BUFFER_BYTES = LineBufferBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] rx_byte
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o    // period, high time, motor_on, zeros
);

  scps_cmd_t          cmd;
  scps_sts_t          sts;
  logic [PeriodW-1:0] period_val;
  logic [PeriodW-1:0] high_val;
  logic               motor_on;

  scps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scps_dp #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .period_o    (period_val),
    .high_o      (high_val),
    .motor_on_o  (motor_on)
  );

  assign m_axis_tdata_o = {(OutDataW - 2*PeriodW - 1)'(0), motor_on, high_val, period_val};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result loaded over an untaken transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !motor_on) |-> (period_val == '0 && high_val == '0))
    else $error("nonzero timing with the output off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (high_val <= period_val))
    else $error("pulse longer than period");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step || cmd.recip || cmd.split || cmd.scale) |-> !s_axis_tready_o)
    else $error("input taken during a computation");

endmodule

`default_nettype wire
